// ===== hdl/lfrd_pkg.sv =====
// shared constants and controller/datapath interface types for the range draw unit
package lfrd_pkg;

  // width of the bound and result fields
  localparam int unsigned FIELD_W = 30;
  // generator words are shifted right by this much before masking
  localparam int unsigned DRAW_SHIFT = 6;

  // commands from controller to datapath
  typedef struct packed {
    logic init_write;  // write the next reset table entry
    logic capture;     // take the request bounds
    logic draw;        // add taps, write back, advance pointers, test draw
    logic load_out;    // move the finished result into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic init_last;   // last table entry is being written
    logic trivial;     // span of the incoming request is at most one
    logic draw_ok;     // the current draw falls inside the span
    logic out_free;    // output register can take a new result
  } stat_t;

  // smear the highest set bit down to bit zero
  function automatic logic [FIELD_W-1:0] fill_right(input logic [FIELD_W-1:0] x);
    logic [FIELD_W-1:0] m;
    m = x;
    for (int k = 0; k < 5; k++) begin
      m = m | (m >> (1 << k));
    end
    return m;
  endfunction

endpackage

// ===== hdl/lfrd_ctrl.sv =====
// sequencer for table fill, request capture, draw loop and result hand-off
module lfrd_ctrl
  import lfrd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_ADD    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_write = 1'b1;
        if (stat_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = stat_i.trivial ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.draw = 1'b1;
        state_d = stat_i.draw_ok ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/lfrd_datapath.sv =====
// lag table memory, pointers, span logic, draw test and output register
module lfrd_datapath
  import lfrd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 55,
  parameter int unsigned SHORT_LAG   = 24,
  parameter int unsigned WORD_BITS   = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o,
  input  logic signed [FIELD_W-1:0] lower_bound_i,
  input  logic signed [FIELD_W-1:0] upper_bound_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [FIELD_W-1:0] value_o
);

  localparam int unsigned PTR_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned DRAW_W    = WORD_BITS - DRAW_SHIFT;
  localparam int unsigned TAP_RESET = (TABLE_DEPTH - (SHORT_LAG % TABLE_DEPTH)) % TABLE_DEPTH;
  localparam int unsigned TAP_WRAP  = TABLE_DEPTH - TAP_RESET;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(TABLE_DEPTH - 1);

  logic [WORD_BITS-1:0] lag_mem [TABLE_DEPTH];
  logic [WORD_BITS-1:0] rd_w_q, rd_p_q;
  logic [PTR_W-1:0]     wp_q, wp_d, tp_q, tp_d;
  logic [PTR_W-1:0]     init_idx_q, init_idx_d;
  logic [WORD_BITS-1:0] fib_prev_q, fib_prev_d, fib_cur_q, fib_cur_d;
  logic                 out_valid_q, out_valid_d;

  logic signed [FIELD_W-1:0] lo_q, result_q;
  logic [FIELD_W-1:0]        diff_q, mask_q;
  logic [FIELD_W-1:0]        value_q;

  logic signed [FIELD_W:0] diff_full;
  logic [WORD_BITS-1:0]    sum;
  logic [DRAW_W-1:0]       masked;
  logic [FIELD_W-1:0]      masked_ext;
  logic                    mem_we;
  logic [PTR_W-1:0]        mem_waddr;
  logic [WORD_BITS-1:0]    mem_wdata;

  // span test on the incoming request
  assign diff_full = $signed({upper_bound_i[FIELD_W-1], upper_bound_i})
                   - $signed({lower_bound_i[FIELD_W-1], lower_bound_i});

  // generator sum and masked draw
  assign sum        = rd_w_q + rd_p_q;
  assign masked     = sum[WORD_BITS-1:DRAW_SHIFT] & mask_q[DRAW_W-1:0];
  assign masked_ext = {{(FIELD_W - DRAW_W){1'b0}}, masked};

  // status
  assign stat_o.init_last = (init_idx_q == LAST_IDX);
  assign stat_o.trivial   = diff_full[FIELD_W] || (diff_full == '0);
  assign stat_o.draw_ok   = (masked_ext <= diff_q);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // memory write select: reset fill or draw write-back
  assign mem_we    = cmd_i.init_write || cmd_i.draw;
  assign mem_waddr = cmd_i.init_write ? init_idx_q : wp_q;
  assign mem_wdata = cmd_i.init_write ? fib_cur_q : sum;

  // lag table, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) lag_mem[mem_waddr] <= mem_wdata;
    rd_w_q <= lag_mem[wp_q];
    rd_p_q <= lag_mem[tp_q];
  end

  // pointer and fill sequence next values
  always_comb begin
    wp_d        = wp_q;
    tp_d        = tp_q;
    init_idx_d  = init_idx_q;
    fib_prev_d  = fib_prev_q;
    fib_cur_d   = fib_cur_q;
    out_valid_d = out_valid_q;
    if (cmd_i.draw) begin
      wp_d = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
      tp_d = (tp_q == LAST_IDX) ? '0 : tp_q + 1'b1;
    end
    if (cmd_i.init_write) begin
      init_idx_d = init_idx_q + 1'b1;
      fib_prev_d = fib_cur_q;
      fib_cur_d  = fib_cur_q + fib_prev_q;
    end
    if (!out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.load_out) out_valid_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      tp_q        <= PTR_W'(TAP_RESET);
      init_idx_q  <= '0;
      fib_prev_q  <= '0;
      fib_cur_q   <= WORD_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      tp_q        <= tp_d;
      init_idx_q  <= init_idx_d;
      fib_prev_q  <= fib_prev_d;
      fib_cur_q   <= fib_cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lo_q     <= lower_bound_i;
      diff_q   <= diff_full[FIELD_W-1:0];
      mask_q   <= fill_right(diff_full[FIELD_W-1:0]);
      result_q <= lower_bound_i;
    end
    if (cmd_i.draw && stat_o.draw_ok) begin
      result_q <= lo_q + $signed(masked_ext);
    end
    if (cmd_i.load_out) begin
      value_q <= result_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(value_q);

  // tap pointer keeps its fixed distance ahead of the write pointer, wrapping at the depth
  a_ptr_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(wp_q) + int'(TAP_RESET)
     - ((int'(wp_q) >= int'(TAP_WRAP)) ? int'(TABLE_DEPTH) : 0)) == int'(tp_q))
    else $error("tap pointer lost its lag");

  // pointers stay inside the table
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(wp_q) < int'(TABLE_DEPTH)) && (int'(tp_q) < int'(TABLE_DEPTH)))
    else $error("pointer beyond table depth");

  // a result never overwrites one still held by a stalled receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  // no draw while the table fill is still running
  a_fill_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.init_write |-> !cmd_i.draw && !cmd_i.capture)
    else $error("draw or request during table fill");

endmodule

// ===== hdl/lagged_fibonacci_range_draw_unit.sv =====
// top level of the lagged fibonacci range draw unit
//
// Usage: a request carries lower_bound_i and upper_bound_i (inclusive, signed)
// on the input channel (in_valid_i / in_stall_o). One result per request leaves
// on value_o over the output channel (out_valid_o / out_stall_i). A request is
// taken when valid is high and stall is low.
// Requests whose span is at most one (including upper below lower) return the
// lower bound and do not step the generator.
// Other requests pass through capture, one or more generator draws (each a
// table read, then add and write-back) and hand-off, with the number of draws
// averaging under two. Each draw is split into the read and the add by the
// registered read of the lag table memory and the write-back of each sum.
// One request is in work at a time; the next is taken as soon as the result
// has moved into the output register, even while the receiver stalls.
// At reset the table is filled with the fibonacci sequence, one entry per
// cycle, all TABLE_DEPTH entries, during which in_stall_o stays high.
// A stalled result holds on value_o; a finished draw waits until it is free.
module lagged_fibonacci_range_draw_unit
  import lfrd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 55,
  parameter int unsigned SHORT_LAG   = 24,
  parameter int unsigned WORD_BITS   = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] lower_bound_i,
  input  logic signed [FIELD_W-1:0] upper_bound_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [FIELD_W-1:0] value_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  lfrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // generator and range datapath
  lfrd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SHORT_LAG   (SHORT_LAG),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .lower_bound_i (lower_bound_i),
    .upper_bound_i (upper_bound_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o)
  );

endmodule

// ===== test/range_draw_checker.sv =====
// checker for the range draw unit: predicts each drawn value and compares it
`timescale 1ns / 1ps

module range_draw_checker
  import lfrd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 55,
  parameter int unsigned SHORT_LAG   = 24,
  parameter int unsigned WORD_BITS   = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [FIELD_W-1:0] lower_bound_i,
  input  logic signed [FIELD_W-1:0] upper_bound_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [FIELD_W-1:0] value_i,
  output int                        fail_count_o,
  output int                        pending_count_o
);

  // own copy of the generator state
  logic [WORD_BITS-1:0] lag_words [TABLE_DEPTH];
  int unsigned          wr_ptr;
  int unsigned          tap_ptr;

  // drawn values still owed by the block, oldest first
  logic [FIELD_W-1:0] expected_values [$];

  // reload the table with the fibonacci sequence and rewind both pointers
  task automatic reset_generator();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i < 2) lag_words[i] = 1;
      else       lag_words[i] = lag_words[i-1] + lag_words[i-2];
    end
    wr_ptr  = 0;
    tap_ptr = (TABLE_DEPTH - (SHORT_LAG % TABLE_DEPTH)) % TABLE_DEPTH;
  endtask

  // one generator step: add the two taps, write back, advance, drop low bits
  function automatic longint next_draw();
    logic [WORD_BITS-1:0] sum;
    sum = lag_words[wr_ptr] + lag_words[tap_ptr];
    lag_words[wr_ptr] = sum;
    wr_ptr  = (wr_ptr + 1 == TABLE_DEPTH) ? 0 : wr_ptr + 1;
    tap_ptr = (tap_ptr + 1 == TABLE_DEPTH) ? 0 : tap_ptr + 1;
    return longint'(sum >> DRAW_SHIFT);
  endfunction

  // value for one request; empty or single-value ranges leave the generator alone
  function automatic logic [FIELD_W-1:0] predict_draw(
    input logic signed [FIELD_W-1:0] lo,
    input logic signed [FIELD_W-1:0] hi
  );
    longint             span;
    longint             power;
    longint             offset;
    logic [FIELD_W-1:0] drawn;
    span = longint'(hi) - longint'(lo) + 1;
    if (span <= 1) return lo;
    power = 2;
    while (power < span) power = power << 1;
    // reject draws that land outside the span
    do begin
      offset = next_draw() & (power - 1);
    end while (offset >= span);
    drawn = longint'(lo) + offset;
    return drawn;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  // watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic [FIELD_W-1:0] want;
    if (!rst_ni) begin
      reset_generator();
      expected_values.delete();
    end else begin
      // accepted request: work out the value it must produce
      if (in_valid_i && !in_stall_i) begin
        expected_values.push_back(predict_draw(lower_bound_i, upper_bound_i));
      end
      // accepted result: compare with the oldest owed value
      if (out_valid_i && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("value %0d with no request waiting", value_i));
        end else begin
          want = expected_values.pop_front();
          if (value_i !== want) begin
            report_mismatch($sformatf("value %0d, expected %0d", value_i,
                                      $signed(want)));
          end
        end
      end
    end
    pending_count_o = expected_values.size();
  end

endmodule

// ===== test/tb.sv =====
// top of the range draw testbench: clock, reset, requests, stalls and verdict
`timescale 1ns / 1ps

module tb;
  import lfrd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1800;
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam longint FULL_SPAN = longint'(1) << FIELD_W;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [FIELD_W-1:0] lower_bound_i = '0;
  logic signed [FIELD_W-1:0] upper_bound_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [FIELD_W-1:0] value_o;

  int mismatch_count;
  int owed_values;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  lagged_fibonacci_range_draw_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .lower_bound_i (lower_bound_i),
    .upper_bound_i (upper_bound_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o)
  );

  range_draw_checker draw_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .lower_bound_i   (lower_bound_i),
    .upper_bound_i   (upper_bound_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_i         (value_o),
    .fail_count_o    (mismatch_count),
    .pending_count_o (owed_values)
  );

  always #6 clk_i = ~clk_i;

  // receiver stalls about a quarter of the time, never during the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 25);
  end

  // give up when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("lagged_fibonacci_range_draw_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request, with an optional idle gap first; returns at the accepting edge
  task automatic send_request(
    input logic signed [FIELD_W-1:0] lo,
    input logic signed [FIELD_W-1:0] hi
  );
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    lower_bound_i <= lo;
    upper_bound_i <= hi;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // request with a given span placed anywhere it fits
  task automatic send_span(input longint span);
    longint lo;
    lo = longint'($urandom_range(0, FULL_SPAN - span)) + longint'(FIELD_MIN);
    send_request(lo, lo + span - 1);
  endtask

  // hold off until every owed value has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (owed_values != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int     pick;
    int     k;
    longint span;
    logic signed [FIELD_W-1:0] lo;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full range, single values, reversed bounds, small spans
    send_request(FIELD_MIN, FIELD_MAX);
    send_request(FIELD_MAX, FIELD_MAX);
    send_request(FIELD_MIN, FIELD_MIN);
    send_request(FIELD_MAX, FIELD_MIN);
    send_request(0, -1);
    send_request(0, 1);
    send_request(-1, 0);
    send_request(FIELD_MAX - 1, FIELD_MAX);
    send_request(FIELD_MIN, FIELD_MIN + 1);
    send_request(-5, -3);
    send_request(100, 104);
    send_request(-17, 46);
    // spans around the draw width, where masking stops rejecting
    send_request(0, (1 << 24) - 2);
    send_request(0, (1 << 24) - 1);
    send_request(-7, (1 << 24) - 7);
    send_request(FIELD_MIN, FIELD_MIN + (1 << 25));
    send_request(FIELD_MAX - (1 << 28), FIELD_MAX);
    send_request(FIELD_MIN + 1, FIELD_MAX);
    send_request(FIELD_MIN, FIELD_MAX - 1);
    send_request(-(1 << 28), (1 << 28));

    wait_for_drain();

    // random: mostly real draws, some trivial and fully random bounds
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_span($urandom_range(2, 70));
      end else if (pick < 65) begin
        // just below, at and above a power of two
        k = $urandom_range(1, FIELD_W);
        span = (longint'(1) << k) + $urandom_range(0, 2) - 1;
        if (span < 2) span = 2;
        if (span > FULL_SPAN) span = FULL_SPAN;
        send_span(span);
      end else if (pick < 80) begin
        send_request($urandom(), $urandom());
      end else if (pick < 90) begin
        lo = $urandom();
        send_request(lo, lo - $urandom_range(0, 3));
      end else begin
        send_span(longint'($urandom_range(2, 32'h3fff_ffff)) + $urandom_range(0, 1));
      end
    end
    calm = 1'b0;

    wait_for_drain();
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("lagged_fibonacci_range_draw_unit: match");
    end else begin
      $display("lagged_fibonacci_range_draw_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lfrd_pkg.sv
hdl/lfrd_ctrl.sv
hdl/lfrd_datapath.sv
hdl/lagged_fibonacci_range_draw_unit.sv
test/range_draw_checker.sv
test/tb.sv
